// ===== rtl/core/ksd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_pkg: shared types and constants for the shake detector
// Holds the controller states, the multiplier operation codes, the command and
// status groups between controller and datapath, and the register map.
// ----------------------------------------------------------------------------
package ksd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } ksd_state_t;

    typedef enum logic [1:0] {
        OP_X,
        OP_Y,
        OP_Z,
        OP_COV
    } ksd_op_t;

    typedef struct packed {
        logic    capture;
        logic    load;
        logic    div_step;
        logic    div_first;
        logic    mul_issue;
        ksd_op_t mul_op;
        logic    sum_calc;
        logic    out_load;
    } ksd_cmd_t;

    typedef struct packed {
        logic out_free;
    } ksd_status_t;

    localparam logic [1:0] REG_PROC_NOISE  = 2'd0;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_SHAKE_THR   = 2'd2;

    localparam logic [23:0] PROC_NOISE_RST = 24'd655;
    localparam logic [23:0] MEAS_NOISE_RST = 24'd655360;
    localparam logic [16:0] SHAKE_THR_RST  = 17'd1000;

    localparam logic [16:0] ONE_Q16        = 17'h10000;
    localparam logic [31:0] COV_RST        = 32'h0001_0000;
    localparam logic [16:0] SUM_MAX        = 17'd98304;

    localparam logic [4:0]  DIV_LAST       = 5'd16;
    localparam logic [4:0]  MUL_ISSUE_END  = 5'd4;
    localparam logic [4:0]  MUL_LAST       = 5'd5;

endpackage

// ===== rtl/core/ksd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_ctrl: sequencing controller
// Walks each request through covariance load, gain division, the shared
// multiplier passes, the magnitude sum and the output register load.
// ----------------------------------------------------------------------------
module ksd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ksd_pkg::ksd_status_t status,
    output ksd_pkg::ksd_cmd_t    cmd
);

    ksd_pkg::ksd_state_t state_reg;
    ksd_pkg::ksd_state_t state_next;
    logic [4:0]          cnt_reg;
    logic [4:0]          cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ksd_pkg::ST_IDLE;
            cnt_reg   <= 5'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ksd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ksd_pkg::ST_LOAD;
                end
            end
            ksd_pkg::ST_LOAD: begin
                state_next = ksd_pkg::ST_DIV;
                cnt_next   = 5'd0;
            end
            ksd_pkg::ST_DIV: begin
                if (cnt_reg == ksd_pkg::DIV_LAST) begin
                    state_next = ksd_pkg::ST_MUL;
                    cnt_next   = 5'd0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ksd_pkg::ST_MUL: begin
                if (cnt_reg == ksd_pkg::MUL_LAST) begin
                    state_next = ksd_pkg::ST_SUM;
                    cnt_next   = 5'd0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ksd_pkg::ST_SUM: begin
                state_next = ksd_pkg::ST_OUT;
            end
            ksd_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = ksd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ksd_pkg::ST_IDLE;
                cnt_next   = 5'd0;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.div_first = 1'b0;
        cmd.mul_issue = 1'b0;
        cmd.mul_op    = ksd_pkg::ksd_op_t'(cnt_reg[1:0]);
        cmd.sum_calc  = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ksd_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ksd_pkg::ST_LOAD: begin
                cmd.load = 1'b1;
            end
            ksd_pkg::ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == 5'd0);
            end
            ksd_pkg::ST_MUL: begin
                cmd.mul_issue = (cnt_reg < ksd_pkg::MUL_ISSUE_END);
            end
            ksd_pkg::ST_SUM: begin
                cmd.sum_calc = 1'b1;
            end
            ksd_pkg::ST_OUT: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/ksd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_datapath: filter arithmetic and result register
// Restoring divider for the gain, one shared pipelined multiplier for the
// three axis updates and the covariance update, and the output register.
// ----------------------------------------------------------------------------
module ksd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ksd_pkg::ksd_cmd_t    cmd,
    output ksd_pkg::ksd_status_t status,
    input  logic [15:0]          acc_x,
    input  logic [15:0]          acc_y,
    input  logic [15:0]          acc_z,
    input  logic [23:0]          process_noise,
    input  logic [23:0]          measure_noise,
    input  logic [16:0]          thresh_level,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [15:0]          filt_x,
    output logic [15:0]          filt_y,
    output logic [15:0]          filt_z,
    output logic [16:0]          magnitude_sum,
    output logic                 shake
);

    logic [15:0]        samp_x_reg;
    logic [15:0]        samp_y_reg;
    logic [15:0]        samp_z_reg;
    logic [31:0]        p1_reg;
    logic [32:0]        den_reg;
    logic               den_zero_reg;
    logic [33:0]        rem_reg;
    logic [16:0]        quo_reg;
    logic [31:0]        est_x_reg;
    logic [31:0]        est_y_reg;
    logic [31:0]        est_z_reg;
    logic [31:0]        cov_reg;
    logic signed [33:0] op_a_reg;
    logic signed [17:0] op_b_reg;
    logic               a_vld_reg;
    ksd_pkg::ksd_op_t   a_op_reg;
    logic signed [51:0] prod_reg;
    logic               p_vld_reg;
    ksd_pkg::ksd_op_t   p_op_reg;
    logic [33:0]        sum_reg;
    logic               m_tvalid_reg;
    logic [15:0]        filt_x_reg;
    logic [15:0]        filt_y_reg;
    logic [15:0]        filt_z_reg;
    logic [16:0]        mag_reg;
    logic               shake_reg;

    logic [32:0] p_plus_q;
    logic [31:0] p1_sat;
    logic [33:0] rem_cur;
    logic        rem_ge;
    logic [16:0] gain;
    logic [15:0] iss_samp;
    logic [31:0] iss_est;
    logic [33:0] iss_diff;
    logic [31:0] wb_est;
    logic [36:0] wb_sum;
    logic [31:0] wb_sat;
    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic [31:0] abs_z;
    logic [17:0] whole;

    assign p_plus_q = {1'b0, cov_reg} + {9'd0, process_noise};
    assign p1_sat   = p_plus_q[32] ? 32'hFFFF_FFFF : p_plus_q[31:0];

    assign rem_cur = cmd.div_first ? rem_reg : {rem_reg[32:0], 1'b0};
    assign rem_ge  = (rem_cur >= {1'b0, den_reg});
    assign gain    = den_zero_reg ? 17'd0 : quo_reg;

    always_comb begin
        case (cmd.mul_op)
            ksd_pkg::OP_X: begin
                iss_samp = samp_x_reg;
                iss_est  = est_x_reg;
            end
            ksd_pkg::OP_Y: begin
                iss_samp = samp_y_reg;
                iss_est  = est_y_reg;
            end
            ksd_pkg::OP_Z: begin
                iss_samp = samp_z_reg;
                iss_est  = est_z_reg;
            end
            default: begin
                iss_samp = samp_z_reg;
                iss_est  = est_z_reg;
            end
        endcase
    end

    assign iss_diff = {{2{iss_samp[15]}}, iss_samp, 16'h0000}
                    - {{2{iss_est[31]}}, iss_est};

    always_comb begin
        case (p_op_reg)
            ksd_pkg::OP_X:   wb_est = est_x_reg;
            ksd_pkg::OP_Y:   wb_est = est_y_reg;
            ksd_pkg::OP_Z:   wb_est = est_z_reg;
            default:         wb_est = est_z_reg;
        endcase
    end

    // The product shifted right by 16 is the floored increment.
    assign wb_sum = {{5{wb_est[31]}}, wb_est} + {prod_reg[51], prod_reg[51:16]};

    always_comb begin
        if ((wb_sum[36:31] == 6'h00) || (wb_sum[36:31] == 6'h3F)) begin
            wb_sat = wb_sum[31:0];
        end else if (wb_sum[36]) begin
            wb_sat = 32'h8000_0000;
        end else begin
            wb_sat = 32'h7FFF_FFFF;
        end
    end

    assign abs_x = est_x_reg[31] ? (32'd0 - est_x_reg) : est_x_reg;
    assign abs_y = est_y_reg[31] ? (32'd0 - est_y_reg) : est_y_reg;
    assign abs_z = est_z_reg[31] ? (32'd0 - est_z_reg) : est_z_reg;
    assign whole = sum_reg[33:16];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            samp_x_reg <= acc_x;
            samp_y_reg <= acc_y;
            samp_z_reg <= acc_z;
            p1_reg     <= p1_sat;
        end
        if (cmd.load) begin
            den_reg      <= {1'b0, p1_reg} + {9'd0, measure_noise};
            den_zero_reg <= (p1_reg == 32'd0) && (measure_noise == 24'd0);
            rem_reg      <= {2'b00, p1_reg};
            quo_reg      <= 17'd0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? (rem_cur - {1'b0, den_reg}) : rem_cur;
            quo_reg <= {quo_reg[15:0], rem_ge};
        end
        if (cmd.mul_issue) begin
            if (cmd.mul_op == ksd_pkg::OP_COV) begin
                op_a_reg <= {2'b00, p1_reg};
                op_b_reg <= {1'b0, ksd_pkg::ONE_Q16 - gain};
            end else begin
                op_a_reg <= iss_diff;
                op_b_reg <= {1'b0, gain};
            end
            a_op_reg <= cmd.mul_op;
        end
        if (a_vld_reg) begin
            prod_reg <= op_a_reg * op_b_reg;
            p_op_reg <= a_op_reg;
        end
        if (cmd.sum_calc) begin
            sum_reg <= {2'b00, abs_x} + {2'b00, abs_y} + {2'b00, abs_z};
        end
        if (cmd.out_load) begin
            filt_x_reg <= est_x_reg[31:16];
            filt_y_reg <= est_y_reg[31:16];
            filt_z_reg <= est_z_reg[31:16];
            mag_reg    <= (whole > {1'b0, ksd_pkg::SUM_MAX}) ? ksd_pkg::SUM_MAX
                                                              : whole[16:0];
            shake_reg  <= (sum_reg > {1'b0, thresh_level, 16'h0000});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_x_reg    <= 32'd0;
            est_y_reg    <= 32'd0;
            est_z_reg    <= 32'd0;
            cov_reg      <= ksd_pkg::COV_RST;
            a_vld_reg    <= 1'b0;
            p_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            a_vld_reg <= cmd.mul_issue;
            p_vld_reg <= a_vld_reg;
            if (p_vld_reg) begin
                case (p_op_reg)
                    ksd_pkg::OP_X:   est_x_reg <= wb_sat;
                    ksd_pkg::OP_Y:   est_y_reg <= wb_sat;
                    ksd_pkg::OP_Z:   est_z_reg <= wb_sat;
                    ksd_pkg::OP_COV: cov_reg   <= prod_reg[47:16];
                    default:         cov_reg   <= cov_reg;
                endcase
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign filt_x          = filt_x_reg;
    assign filt_y          = filt_y_reg;
    assign filt_z          = filt_z_reg;
    assign magnitude_sum   = mag_reg;
    assign shake           = shake_reg;

endmodule

// ===== rtl/core/kalman_shake_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_shake_detector: three-axis scalar Kalman filter with shake flag
// An accepted request passes through the divider load, the gain divider, the
// shared multiplier, the magnitude sum and the output register in turn. Only one
// request is in work at a time; a result left waiting at the output holds the
// next one in its final step.
// Reset: synchronous, active low; estimates clear to zero, covariance to 1.0
// and the registers to their defaults.
// ----------------------------------------------------------------------------
module kalman_shake_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // acc_x[15:0], acc_y[31:16], acc_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // filt_x, filt_y, filt_z, magnitude_sum, shake, zeros
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ksd_pkg::ksd_cmd_t    cmd;
    ksd_pkg::ksd_status_t status;

    logic [23:0] proc_noise_reg;
    logic [23:0] meas_noise_reg;
    logic [16:0] shake_thr_reg;
    logic        cfg_wr;

    logic [15:0] filt_x;
    logic [15:0] filt_y;
    logic [15:0] filt_z;
    logic [16:0] magnitude_sum;
    logic        shake;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_noise_reg <= ksd_pkg::PROC_NOISE_RST;
            meas_noise_reg <= ksd_pkg::MEAS_NOISE_RST;
            shake_thr_reg  <= ksd_pkg::SHAKE_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ksd_pkg::REG_PROC_NOISE: proc_noise_reg <= pwdata[23:0];
                ksd_pkg::REG_MEAS_NOISE: meas_noise_reg <= pwdata[23:0];
                ksd_pkg::REG_SHAKE_THR:  shake_thr_reg  <= pwdata[16:0];
                default:                 shake_thr_reg  <= shake_thr_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ksd_pkg::REG_PROC_NOISE: prdata = {8'd0, proc_noise_reg};
            ksd_pkg::REG_MEAS_NOISE: prdata = {8'd0, meas_noise_reg};
            ksd_pkg::REG_SHAKE_THR:  prdata = {15'd0, shake_thr_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    ksd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ksd_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .acc_x           (s_tdata[15:0]),
        .acc_y           (s_tdata[31:16]),
        .acc_z           (s_tdata[47:32]),
        .process_noise   (proc_noise_reg),
        .measure_noise   (meas_noise_reg),
        .thresh_level    (shake_thr_reg),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .filt_x          (filt_x),
        .filt_y          (filt_y),
        .filt_z          (filt_z),
        .magnitude_sum   (magnitude_sum),
        .shake           (shake)
    );

    assign m_tdata = {6'd0, shake, magnitude_sum, filt_z, filt_y, filt_x};

endmodule

// ===== rtl/core/ksd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_checker: port-level assertions for the shake detector
// Checks reset, the one-request-at-a-time sequencing, stalls and the result format.
// ----------------------------------------------------------------------------
module ksd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is in work");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared right after a request was accepted");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    a_result_format: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[71:66] == 6'd0) && (m_tdata[64:48] <= 17'd98304)))
        else $error("result padding or magnitude out of range");

endmodule

bind kalman_shake_detector ksd_checker u_ksd_checker (.*);

// ===== bench/tb_kalman_shake_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_shake_detector: self-checking bench for the three-axis shake detector
// Sends accelerometer requests through the input stream and keeps a bit-exact
// fixed-point copy of the shared-gain Kalman filter. Every result is compared
// field by field with the oldest pending entry. A directed table covers reset
// values, unity and zero gain, threshold edges and register masking. Random
// phases then follow, with new noise and threshold settings written between
// phases and read back. Both stream sides stall at random except in the last
// phase.
// ----------------------------------------------------------------------------
module tb_kalman_shake_detector;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 80;
    localparam int PLAN_ROWS      = 24;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        logic        shake;
        logic [16:0] mag_sum;
        logic [15:0] filt_z;
        logic [15:0] filt_y;
        logic [15:0] filt_x;
    } reading_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] wval;
        logic [15:0] acc_x;
        logic [15:0] acc_y;
        logic [15:0] acc_z;
        logic        typed;
        reading_t    want;
    } plan_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // acc_x[15:0], acc_y[31:16], acc_z[47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // filt_x, filt_y, filt_z, magnitude_sum, shake, zeros
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    logic signed [31:0] trk_x   = '0;
    logic signed [31:0] trk_y   = '0;
    logic signed [31:0] trk_z   = '0;
    logic [31:0]        cov_q16 = ksd_pkg::COV_RST;
    logic [23:0]        proc_q  = ksd_pkg::PROC_NOISE_RST;
    logic [23:0]        meas_r  = ksd_pkg::MEAS_NOISE_RST;
    logic [16:0]        thr_int = ksd_pkg::SHAKE_THR_RST;

    reading_t pending [$];
    int       errors      = 0;
    bit       calm        = 1'b0;
    int       stall_left  = 0;
    int       idle_cycles = 0;

    plan_row_t dir_plan [PLAN_ROWS] = '{
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1,
          '{1'b0, 17'd0, 16'd0, 16'd0, 16'd0}},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'd100, 16'hFF9C, 16'd7, 1'b0, '0},
        '{ROW_WRITE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_WRITE, ksd_pkg::REG_MEAS_NOISE, 32'hFF00_0000, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'h7FFF, 16'h8000, 16'd1, 1'b1,
          '{1'b1, 17'd65536, 16'd1, 16'h8000, 16'h7FFF}},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'd5, 16'd5, 16'd5, 1'b1,
          '{1'b1, 17'd65536, 16'd1, 16'h8000, 16'h7FFF}},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
          '{1'b1, 17'd65536, 16'd1, 16'h8000, 16'h7FFF}},
        '{ROW_WRITE, ksd_pkg::REG_PROC_NOISE, 32'd1, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_WRITE, ksd_pkg::REG_SHAKE_THR, 32'd98304, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'h8000, 16'h8000, 16'h8000, 1'b1,
          '{1'b0, 17'd98304, 16'h8000, 16'h8000, 16'h8000}},
        '{ROW_WRITE, ksd_pkg::REG_SHAKE_THR, 32'd98303, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'h8000, 16'h8000, 16'h8000, 1'b1,
          '{1'b1, 17'd98304, 16'h8000, 16'h8000, 16'h8000}},
        '{ROW_WRITE, ksd_pkg::REG_SHAKE_THR, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1,
          '{1'b0, 17'd0, 16'd0, 16'd0, 16'd0}},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'd0, 16'd0, 16'd1, 1'b1,
          '{1'b1, 17'd1, 16'd1, 16'd0, 16'd0}},
        '{ROW_WRITE, ksd_pkg::REG_SHAKE_THR, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
          '{1'b0, 17'd98301, 16'h7FFF, 16'h7FFF, 16'h7FFF}},
        '{ROW_WRITE, REG_NONE, 32'h1234_5678, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_WRITE, ksd_pkg::REG_PROC_NOISE, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_WRITE, ksd_pkg::REG_MEAS_NOISE, 32'h00FF_FFFF, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'h8000, 16'h7FFF, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'd1, 16'hFFFF, 16'h8000, 1'b0, '0},
        '{ROW_WRITE, ksd_pkg::REG_SHAKE_THR, 32'd1000, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, ksd_pkg::REG_PROC_NOISE, 32'd0, 16'h3039, 16'hCFC7, 16'd0, 1'b0, '0}
    };

    kalman_shake_detector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    function automatic logic signed [31:0] track_axis(input logic signed [31:0] est,
                                                      input logic signed [15:0] smp,
                                                      input logic [16:0] gain);
        longint diff;
        longint nxt;
        longint kk;
        kk   = longint'(gain);
        diff = longint'(smp) * 65536 - longint'(est);
        nxt  = longint'(est) + ((diff * kk) >>> 16);
        if (nxt > longint'(32'sh7FFF_FFFF)) nxt = longint'(32'sh7FFF_FFFF);
        if (nxt < longint'(32'sh8000_0000)) nxt = longint'(32'sh8000_0000);
        return nxt[31:0];
    endfunction

    function automatic logic [63:0] mag_of(input logic signed [31:0] v);
        return (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
    endfunction

    function automatic reading_t kalman_step(input logic [15:0] ax, ay, az);
        logic [63:0] p1;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] sum;
        logic [63:0] whole;
        reading_t    res;
        p1 = 64'(cov_q16) + 64'(proc_q);
        if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
        den  = p1 + 64'(meas_r);
        gain = (den == 64'd0) ? 64'd0 : (p1 << 16) / den;
        trk_x = track_axis(trk_x, ax, gain[16:0]);
        trk_y = track_axis(trk_y, ay, gain[16:0]);
        trk_z = track_axis(trk_z, az, gain[16:0]);
        cov_q16 = 32'((p1 * (64'd65536 - gain)) >> 16);
        sum   = mag_of(trk_x) + mag_of(trk_y) + mag_of(trk_z);
        whole = sum >> 16;
        if (whole > 64'(ksd_pkg::SUM_MAX)) whole = 64'(ksd_pkg::SUM_MAX);
        res.filt_x  = trk_x[31:16];
        res.filt_y  = trk_y[31:16];
        res.filt_z  = trk_z[31:16];
        res.mag_sum = whole[16:0];
        res.shake   = (sum > (64'(thr_int) << 16));
        return res;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3, 4, 5: return 16'($urandom());
            default: return 16'($urandom_range(0, 400) - 200);
        endcase
    endfunction

    function automatic logic [31:0] pick_noise();
        logic [31:0] upper;
        upper = $urandom() & 32'hFF00_0000;
        case ($urandom_range(0, 5))
            0: return upper;
            1: return upper | 32'h00FF_FFFF;
            2: return upper | $urandom_range(0, 2000);
            3: return upper | 32'(ksd_pkg::MEAS_NOISE_RST);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd98304;
            2: return $urandom();
            3: return $urandom_range(0, 98304);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic send_request(input logic [15:0] ax, ay, az,
                                input logic typed, input reading_t want);
        reading_t predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        do @(posedge aclk); while (!s_tready);
        predicted = kalman_step(ax, ay, az);
        pending.push_back(typed ? want : predicted);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // The block must be idle, so new requests stop and all results drain first.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        apb_access(1'b1, idx, value, rd);
        case (idx)
            ksd_pkg::REG_PROC_NOISE: proc_q  = value[23:0];
            ksd_pkg::REG_MEAS_NOISE: meas_r  = value[23:0];
            ksd_pkg::REG_SHAKE_THR:  thr_int = value[16:0];
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            apb_access(1'b0, 2'(i), 32'd0, rd);
            case (2'(i))
                ksd_pkg::REG_PROC_NOISE: want = 32'(proc_q);
                ksd_pkg::REG_MEAS_NOISE: want = 32'(meas_r);
                default:                 want = 32'(thr_int);
            endcase
            check_field("register readback", longint'(want), longint'(rd));
        end
    endtask

    always @(posedge aclk) begin : sink_pacing
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        reading_t want;
        reading_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[65:0];
            if (pending.size() == 0) begin
                errors++;
                $display("%0t ns: result with no request pending, expected none actual %h",
                         $time, m_tdata);
            end else begin
                want = pending.pop_front();
                check_field("filt_x", $signed(want.filt_x), $signed(got.filt_x));
                check_field("filt_y", $signed(want.filt_y), $signed(got.filt_y));
                check_field("filt_z", $signed(want.filt_z), $signed(got.filt_z));
                check_field("magnitude_sum", want.mag_sum, got.mag_sum);
                check_field("shake", want.shake, got.shake);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_plan[i]) begin
            if (dir_plan[i].kind == ROW_WRITE) begin
                write_register(dir_plan[i].reg_idx, dir_plan[i].wval);
            end else begin
                send_request(dir_plan[i].acc_x, dir_plan[i].acc_y, dir_plan[i].acc_z,
                             dir_plan[i].typed, dir_plan[i].want);
            end
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == PHASES - 1);
            write_register(ksd_pkg::REG_PROC_NOISE, pick_noise());
            write_register(ksd_pkg::REG_MEAS_NOISE, pick_noise());
            write_register(ksd_pkg::REG_SHAKE_THR, pick_threshold());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
